// ===== design/bsch_pkg.sv =====
// Shared types and constants of the binned sum/count histogram.
package bsch_pkg;

    // Field widths (fixed by the stream format)
    localparam int FUNC_W     = 1;
    localparam int COL_W      = 6;
    localparam int BIN_W      = 7;
    localparam int OUT_W      = 32;
    localparam int THR_W      = 17;
    localparam int MINC_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // Widest counter the ratio unit handles
    localparam int CNT_MAX_W  = 64;

    // Stream packing
    localparam int COL_LO     = 0;
    localparam int BIN_LO     = COL_LO + COL_W;
    localparam int MET_BIT    = BIN_LO + BIN_W;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = FUNC_W;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USED_W = 2 * OUT_W + 1;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ACC  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_READ = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEAST_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_THR    = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD,
        S_TEST,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 valid;
        logic [CNT_MAX_W-1:0] sum;
        logic [CNT_MAX_W-1:0] cnt;
        logic [THR_W-1:0]     thr;
    } t_ratio_req;

    typedef struct packed {
        logic done;
        logic hit;
    } t_ratio_rsp;

endpackage

// ===== design/bsch_ratio.sv =====
// Fraction test sum*65536 >= thr*count, split over four register stages.
module bsch_ratio (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bsch_pkg::t_ratio_req i_req,
    output bsch_pkg::t_ratio_rsp o_rsp
);
    import bsch_pkg::*;

    localparam int HALF_W = CNT_MAX_W / 2;
    localparam int PROD_W = HALF_W + THR_W;
    localparam int WIDE_W = CNT_MAX_W + THR_W;

    logic                 r_v1, r_v2, r_v3, r_v4;
    logic [PROD_W-1:0]    r_plo;
    logic [PROD_W-1:0]    r_plo2;
    logic [PROD_W-1:0]    r_phi;
    logic [HALF_W-1:0]    r_cnt_hi;
    logic [THR_W-1:0]     r_thr;
    logic [CNT_MAX_W-1:0] r_sum1, r_sum2, r_sum3;
    logic [WIDE_W-1:0]    r_rhs;
    logic                 r_hit;
    logic [WIDE_W-1:0]    w_lhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // sum << 16 on the left; 81-bit compare
    assign w_lhs = {1'b0, r_sum3, 16'b0};

    always_ff @(posedge i_clk) begin
        // low half product
        r_plo    <= i_req.cnt[HALF_W-1:0] * i_req.thr;
        r_cnt_hi <= i_req.cnt[CNT_MAX_W-1:HALF_W];
        r_thr    <= i_req.thr;
        r_sum1   <= i_req.sum;
        // high half product
        r_phi    <= r_cnt_hi * r_thr;
        r_plo2   <= r_plo;
        r_sum2   <= r_sum1;
        // recombine
        r_rhs    <= {r_phi, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, r_plo2};
        r_sum3   <= r_sum2;
        r_hit    <= (w_lhs >= r_rhs);
    end

    assign o_rsp.done = r_v4;
    assign o_rsp.hit  = r_hit;

endmodule

// ===== design/binned_sum_count_histogram.sv =====
// Top level: per-column, per-bin sum/count store with rule test.
//
//  port group   dir  payload (low bit first)                 role
//  s_axis_*     in   tdata: column, bin_code, metric_bit     items to apply
//                    tuser: func
//  m_axis_*     out  tdata: bin_sum, bin_count, rule_hit     one result per item
//  i_cfg_*      in   idx 0 least row count, idx 1 positive_thr  register writes
//
// One item at a time: accept, store read, update/write-back, the ratio unit test,
// then output load, which waits while the output register still holds a result.
// After reset the store is cleared one entry per cycle, all NUM_COLUMNS*NUM_BINS
// entries (8192 at default), with tready low; config writes are taken anyway.
// The output register holds a result while the next item is already accepted.
module binned_sum_count_histogram #(
    parameter int NUM_COLUMNS   = 64,
    parameter int NUM_BINS      = 128,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // column[5:0], bin_code[12:6], metric_bit[13], zero fill
    input  logic [bsch_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // func[0]
    input  logic [bsch_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // bin_sum[31:0], bin_count[63:32], rule_hit[64], zero fill
    output logic [bsch_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [bsch_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bsch_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bsch_pkg::*;

    localparam int CW    = COUNTER_WIDTH;
    localparam int DEPTH = NUM_COLUMNS * NUM_BINS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state r_state, n_state;

    logic [2*CW-1:0] mem [DEPTH];
    logic [2*CW-1:0] r_rd;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [2*CW-1:0] mem_wdata;

    logic [AW-1:0]   r_clr_addr;
    logic [MINC_W-1:0] r_least_rows;
    logic [THR_W-1:0]  r_pos_thr;

    logic [COL_W-1:0] w_col;
    logic [BIN_W-1:0] w_bin;
    logic             w_oor;
    logic [AW-1:0]    w_addr;

    logic [AW-1:0]     r_addr;
    logic              r_oor;
    logic [FUNC_W-1:0] r_func;
    logic              r_metric;
    logic              r_bin_nz;

    logic [CW-1:0] old_sum, old_cnt, upd_sum, upd_cnt;
    logic [CW-1:0] r_sum, r_cnt;
    logic          r_cnt_ok;
    logic          r_hit;

    logic                  out_load;
    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [CNT_MAX_W-1:0]  sum_ext, cnt_ext;
    logic [OUT_W-1:0]      sum_clip, cnt_clip;

    t_ratio_req ratio_req;
    t_ratio_rsp ratio_rsp;

    // field decode and address
    assign w_col  = s_axis_tdata[COL_LO +: COL_W];
    assign w_bin  = s_axis_tdata[BIN_LO +: BIN_W];
    assign w_oor  = (32'(w_col) >= NUM_COLUMNS) || (32'(w_bin) >= NUM_BINS);
    assign w_addr = AW'(32'(w_col) * NUM_BINS + 32'(w_bin));

    // read-modify of the fetched entry
    always_comb begin
        old_sum = r_rd[2*CW-1:CW];
        old_cnt = r_rd[CW-1:0];
        upd_sum = old_sum;
        upd_cnt = old_cnt;
        if (r_func == FUNC_ACC) begin
            if (!(&old_cnt)) begin
                upd_cnt = old_cnt + CW'(1);
            end
            if (r_metric && !(&old_sum)) begin
                upd_sum = old_sum + CW'(1);
            end
        end
        if (r_oor) begin
            upd_sum = '0;
            upd_cnt = '0;
        end
    end

    // control
    always_comb begin
        n_state          = r_state;
        s_axis_tready    = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = r_addr;
        mem_wdata        = {upd_sum, upd_cnt};
        ratio_req.valid  = 1'b0;
        ratio_req.sum    = CNT_MAX_W'(upd_sum);
        ratio_req.cnt    = CNT_MAX_W'(upd_cnt);
        ratio_req.thr    = r_pos_thr;
        out_load         = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                mem_we          = !r_oor && (r_func == FUNC_ACC);
                ratio_req.valid = 1'b1;
                n_state         = S_TEST;
            end
            S_TEST: begin
                if (ratio_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_vld || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_out_vld    <= 1'b0;
            r_least_rows <= MINC_W'(1);
            r_pos_thr    <= THR_W'(32768);
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEAST_ROWS: r_least_rows <= i_cfg_data[MINC_W-1:0];
                    CFG_POS_THR:    r_pos_thr    <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[w_addr];
    end

    assign sum_ext  = CNT_MAX_W'(r_sum);
    assign cnt_ext  = CNT_MAX_W'(r_cnt);
    assign sum_clip = (|sum_ext[CNT_MAX_W-1:OUT_W]) ? '1 : sum_ext[OUT_W-1:0];
    assign cnt_clip = (|cnt_ext[CNT_MAX_W-1:OUT_W]) ? '1 : cnt_ext[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_addr   <= w_addr;
            r_oor    <= w_oor;
            r_func   <= s_axis_tuser[FUNC_W-1:0];
            r_metric <= s_axis_tdata[MET_BIT];
            r_bin_nz <= (w_bin != '0);
        end
        if (r_state == S_UPD) begin
            r_sum    <= upd_sum;
            r_cnt    <= upd_cnt;
            r_cnt_ok <= (upd_cnt != '0) &&
                        (CNT_MAX_W'(upd_cnt) >= CNT_MAX_W'(r_least_rows));
        end
        if (r_state == S_TEST && ratio_rsp.done) begin
            r_hit <= ratio_rsp.hit && r_cnt_ok && r_bin_nz;
        end
        if (out_load) begin
            r_out_data <= OUT_DATA_W'({r_hit, cnt_clip, sum_clip});
        end
    end

    bsch_ratio u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ratio_req),
        .o_rsp   (ratio_rsp)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== bench/tb_binned_sum_count_histogram.sv =====
// Self-checking testbench of the binned sum/count histogram, stream ports.
module tb_binned_sum_count_histogram;
    timeunit 1ns;
    timeprecision 1ps;

    import bsch_pkg::*;

    localparam int N_COLS       = 64;
    localparam int N_BINS       = 128;
    localparam int DEPTH        = N_COLS * N_BINS;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 300;

    typedef struct packed {
        logic [OUT_W-1:0] sum;
        logic [OUT_W-1:0] cnt;
        logic             hit;
    } t_bin_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // predictor state
    logic [OUT_W-1:0]  sum_mem [DEPTH];
    logic [OUT_W-1:0]  cnt_mem [DEPTH];
    logic [MINC_W-1:0] least_rows_q;
    logic [THR_W-1:0]  pos_thr_q;

    t_bin_result pending_q [$];
    int          fail_count;
    bit          tx_idle_en;
    bit          rx_idle_en;
    bit          long_hold_req;

    binned_sum_count_histogram u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OUT_W-1:0] sat_inc(input logic [OUT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // applies one item to the shadow store and returns the bin's new state
    function automatic t_bin_result predict_bin(input logic [FUNC_W-1:0] f,
                                                input logic [COL_W-1:0] col,
                                                input logic [BIN_W-1:0] bin,
                                                input logic met);
        int          addr;
        logic [63:0] lhs;
        logic [63:0] rhs;
        t_bin_result r;
        addr = int'(col) * N_BINS + int'(bin);
        if (f == FUNC_ACC) begin
            cnt_mem[addr] = sat_inc(cnt_mem[addr]);
            if (met) sum_mem[addr] = sat_inc(sum_mem[addr]);
        end
        r.sum = sum_mem[addr];
        r.cnt = cnt_mem[addr];
        // sum/count >= thr/65536, cross-multiplied
        lhs = {16'b0, r.sum, 16'b0};
        rhs = 64'(pos_thr_q) * 64'(r.cnt);
        r.hit = (bin != '0) && (r.cnt != '0) && (r.cnt >= least_rows_q) && (lhs >= rhs);
        return r;
    endfunction

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [COL_W-1:0] col,
                             input logic [BIN_W-1:0] bin, input logic met);
        int                   gap;
        logic [IN_DATA_W-1:0] word;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word = '0;
        word[COL_LO +: COL_W] = col;
        word[BIN_LO +: BIN_W] = bin;
        word[MET_BIT] = met;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        pending_q.insert(pending_q.size(), predict_bin(f, col, bin, met));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] min_cnt,
                                input logic [CFG_DATA_W-1:0] thr_word);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LEAST_ROWS;
        i_cfg_data <= min_cnt;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_POS_THR;
        i_cfg_data <= thr_word;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        least_rows_q = min_cnt[MINC_W-1:0];
        pos_thr_q    = thr_word[THR_W-1:0];
    endtask

    // hot bins get many rows so that counts and fractions cross thresholds
    task automatic send_random(input int n, input int met_pct);
        logic [FUNC_W-1:0] f;
        logic [COL_W-1:0]  col;
        logic [BIN_W-1:0]  bin;
        logic              met;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 7) begin
                col = COL_W'($urandom_range(0, 3));
                bin = BIN_W'($urandom_range(0, 7));
            end else begin
                col = COL_W'($urandom());
                bin = BIN_W'($urandom());
            end
            f   = ($urandom_range(0, 4) == 0) ? FUNC_READ : FUNC_ACC;
            met = ($urandom_range(0, 99) < met_pct);
            send_item(f, col, bin, met);
        end
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] word);
        t_bin_result want;
        t_bin_result got;
        got.sum = word[0 +: OUT_W];
        got.cnt = word[OUT_W +: OUT_W];
        got.hit = word[2 * OUT_W];
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result transaction, actual %h", $time, word);
            fail_count++;
            return;
        end
        want = pending_q.pop_front();
        if (got.sum !== want.sum) begin
            $display("%0t: bin_sum mismatch, expected %0d, actual %0d",
                     $time, want.sum, got.sum);
            fail_count++;
        end
        if (got.cnt !== want.cnt) begin
            $display("%0t: bin_count mismatch, expected %0d, actual %0d",
                     $time, want.cnt, got.cnt);
            fail_count++;
        end
        if (got.hit !== want.hit) begin
            $display("%0t: rule_hit mismatch, expected %0b, actual %0b",
                     $time, want.hit, got.hit);
            fail_count++;
        end
    endtask

    // result side: random stalls, or one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) check_result(m_axis_tdata);
            if (long_hold_req) begin
                stall_left    = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        apply_config(32'd1, 32'd32768);
        send_item(FUNC_READ, 6'd0,  7'd0,   1'b0);
        send_item(FUNC_ACC,  6'd0,  7'd0,   1'b1);  // null bin never hits
        send_item(FUNC_ACC,  6'd63, 7'd127, 1'b1);
        send_item(FUNC_ACC,  6'd63, 7'd127, 1'b0);  // exactly one half
        send_item(FUNC_ACC,  6'd63, 7'd127, 1'b0);
        send_item(FUNC_READ, 6'd63, 7'd127, 1'b1);
        send_item(FUNC_ACC,  6'd1,  7'd1,   1'b0);
        send_item(FUNC_READ, 6'd2,  7'd64,  1'b1);
        send_item(FUNC_ACC,  6'd42, 7'd85,  1'b1);
        send_item(FUNC_ACC,  6'd21, 7'd42,  1'b0);
        // zero least row count, zero threshold: empty bins still miss
        apply_config(32'd0, 32'd0);
        send_item(FUNC_READ, 6'd5,  7'd5,   1'b0);
        send_item(FUNC_READ, 6'd1,  7'd1,   1'b0);
        send_item(FUNC_ACC,  6'd0,  7'd0,   1'b0);
        send_item(FUNC_READ, 6'd63, 7'd127, 1'b0);
        // threshold of exactly one
        apply_config(32'd3, 32'd65536);
        repeat (3) send_item(FUNC_ACC, 6'd10, 7'd10, 1'b1);
        send_item(FUNC_ACC,  6'd10, 7'd10,  1'b0);
        send_item(FUNC_READ, 6'd63, 7'd127, 1'b0);
        // threshold above one; upper data bits are dropped by the register
        apply_config(32'd2, 32'hABCF_FFFF);
        send_item(FUNC_ACC,  6'd10, 7'd10, 1'b1);
        send_item(FUNC_READ, 6'd10, 7'd10, 1'b0);
        apply_config(32'hFFFF_FFFF, 32'h0001_0000);
        send_item(FUNC_ACC,  6'd63, 7'd127, 1'b1);
        send_item(FUNC_READ, 6'd0,  7'd0,   1'b0);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 5; p++) begin
            tx_idle_en = (p != 1);
            rx_idle_en = (p != 2);
            case (p)
                0: apply_config(32'd1, 32'd32768);
                1: apply_config(32'd0, 32'd0);
                2: apply_config($urandom_range(2, 6), $urandom_range(0, 65536));
                3: apply_config($urandom_range(1, 4), 32'd65536);
                default: apply_config($urandom_range(0, 12), $urandom());
            endcase
            send_random(120, (p == 3) ? 90 : $urandom_range(20, 80));
        end
    endtask

    // output held off while the sender keeps offering items back to back
    task automatic test_backpressure();
        apply_config($urandom_range(1, 5), $urandom_range(16384, 49152));
        tx_idle_en    = 1'b0;
        rx_idle_en    = 1'b1;
        long_hold_req = 1'b1;
        send_random(40, 50);
    endtask

    task automatic test_drain_pause();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_random(40, 60);
        drain_results();
        send_random(40, 40);
    endtask

    initial begin
        for (int a = 0; a < DEPTH; a++) begin
            sum_mem[a] = '0;
            cnt_mem[a] = '0;
        end
        least_rows_q  = 32'd1;
        pos_thr_q     = 17'd32768;
        fail_count    = 0;
        tx_idle_en    = 1'b0;
        rx_idle_en    = 1'b0;
        long_hold_req = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_settings();
        test_backpressure();
        test_drain_pause();
        drain_results();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
